// ===== rtl/csvp_pkg.sv =====
// Shared types and constants for the CSV integer record parser.
// No dependencies; imported by csv_integer_record_parser_top.
package csvp_pkg;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  localparam int unsigned CFG_ADDR_BITS = 3;

  // Configuration register indexes, selected by paddr[2].
  localparam logic REG_CLAMP_MODE = 1'b0;
  localparam logic REG_MAX_FIELDS = 1'b1;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_t;

  typedef enum logic [1:0] {
    PT_NONE     = 2'd0,
    PT_AFTER_LF = 2'd1,
    PT_AFTER_CR = 2'd2
  } pend_t;

  typedef struct packed {
    logic        empty_record;
    logic        record_end;
    logic        field_stored;
    logic [15:0] field_index;
    logic [63:0] field_value;
  } result_t;

endpackage

// ===== rtl/csv_integer_record_parser_top.sv =====
// CSV integer record parser: byte stream in, one converted field per result out.
// Depends on csvp_pkg for character codes, radix codes and the result type.
//
//   channel  | dir | payload
//   ---------+-----+-------------------------------------------------------------
//   s_*      | in  | tdata: char_byte[7:0]; tlast: end_of_text
//   m_*      | out | tdata: field_value[63:0], field_index[79:64];
//            |     | tlast: record_end; tuser: field_stored[0], empty_record[1]
//   APB      | cfg | 0x0 int_clamp_mode, 0x4 max_fields
//
// Each byte is parsed in the cycle it is accepted, so one item per cycle is sustained while s_tready is high.
// A result enters the output buffer at the end of the cycle that accepts the byte closing its field.
// Results pass through a two-entry output buffer; s_tready drops only when it is full.
// Reset is synchronous and returns the parser to the start of a record.
module csv_integer_record_parser_top
  import csvp_pkg::*;
#(
  parameter int unsigned FIELD_INDEX_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // char_byte[7:0]
  input  logic                     s_tlast,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [79:0]              m_tdata,   // field_value[63:0], field_index[79:64]
  output logic                     m_tlast,
  output logic [1:0]               m_tuser,   // field_stored[0], empty_record[1]
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_X      = 3'd3,
    PH_DIGITS = 3'd4,
    PH_STOP   = 3'd5
  } phase_t;

  localparam logic [FIELD_INDEX_BITS-1:0] CNT_MAX = '1;

  logic                        int_clamp_mode;
  logic [15:0]                 max_fields;

  phase_t                      number_phase, number_phase_next;
  logic                        negative_sign, negative_sign_next;
  radix_t                      radix_select, radix_select_next;
  logic [63:0]                 magnitude, magnitude_next;
  logic                        overflowed, overflowed_next;
  logic [FIELD_INDEX_BITS-1:0] field_counter, field_counter_next;
  logic                        record_has_bytes, record_has_bytes_next;
  pend_t                       pending, pending_next;

  result_t                     ent0, ent1;
  logic [1:0]                  count;

  logic                        s_acc, m_acc, push;
  result_t                     res_new;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      int_clamp_mode <= 1'b0;
      max_fields     <= 16'hFFFF;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_CLAMP_MODE: int_clamp_mode <= pwdata[0];
        REG_MAX_FIELDS: max_fields     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CLAMP_MODE: prdata = {31'd0, int_clamp_mode};
      REG_MAX_FIELDS: prdata = {16'd0, max_fields};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- byte decode
  logic [7:0] c;
  logic       is_dec, is_hex, is_ws, is_sign;
  logic [3:0] dval;
  logic       lead_like;     // leading phase falling into the sign-phase rules
  logic       acc_en;
  logic [4:0] base;
  logic [67:0] prod;
  logic        field_last;
  logic        close_rec, emit_comma;
  logic [63:0] lim, sat;
  logic        cnt_lt;

  assign c = s_tdata;

  always_comb begin
    is_dec = (c >= 8'h30) && (c <= 8'h39);
    is_hex = is_dec || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    if (is_dec)              dval = 4'(c - 8'h30);
    else if (c >= 8'h61)     dval = 4'(c - 8'h57);
    else                     dval = 4'(c - 8'h37);
    is_ws   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    is_sign = (c == CH_PLUS) || (c == CH_MINUS);
  end

  // Digit step: mag*base + d, overflow when the result leaves 64 bits.
  // The radix only changes while the magnitude is still zero, so the current one serves.
  always_comb begin
    case (radix_select)
      RX_HEX:  base = 5'd16;
      RX_OCT:  base = 5'd8;
      default: base = 5'd10;
    endcase
    case (radix_select)
      RX_HEX:  prod = {magnitude, 4'd0} + 68'(dval);
      RX_OCT:  prod = {1'b0, magnitude, 3'd0} + 68'(dval);
      default: prod = {1'b0, magnitude, 3'd0} + {3'd0, magnitude, 1'b0} + 68'(dval);
    endcase
  end

  // Field value with saturation or 32-bit clamping, from the current state.
  always_comb begin
    if (negative_sign) lim = int_clamp_mode ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000;
    else               lim = int_clamp_mode ? 64'h0000_0000_7FFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
    sat    = (overflowed || (magnitude > lim)) ? lim : magnitude;
    cnt_lt = 32'(field_counter) < 32'(max_fields);
  end

  // ---------------------------------------------------------------- parse step
  always_comb begin
    number_phase_next     = number_phase;
    negative_sign_next    = negative_sign;
    radix_select_next     = radix_select;
    magnitude_next        = magnitude;
    overflowed_next       = overflowed;
    field_counter_next    = field_counter;
    record_has_bytes_next = record_has_bytes;
    pending_next          = pending;
    push                  = 1'b0;
    close_rec             = 1'b0;
    emit_comma            = 1'b0;
    acc_en                = 1'b0;
    lead_like             = 1'b0;
    field_last            = 1'b0;

    if (s_acc) begin
      pending_next = PT_NONE;
      if (s_tlast) begin
        close_rec = 1'b1;
      end else if ((c == CH_CR && pending == PT_AFTER_LF) ||
                   (c == CH_LF && pending == PT_AFTER_CR)) begin
        // Second byte of a line-ending pair is swallowed.
      end else if (c == CH_LF || c == CH_CR) begin
        close_rec    = 1'b1;
        pending_next = (c == CH_LF) ? PT_AFTER_LF : PT_AFTER_CR;
      end else begin
        record_has_bytes_next = 1'b1;
        if (c == CH_COMMA) begin
          emit_comma = 1'b1;
          if (field_counter != CNT_MAX) field_counter_next = field_counter + 1'b1;
        end else begin
          case (number_phase)
            PH_LEAD: begin
              if (is_sign) begin
                negative_sign_next = (c == CH_MINUS);
                number_phase_next  = PH_SIGN;
              end else if (!is_ws) begin
                lead_like = 1'b1;
              end
            end
            PH_SIGN:  lead_like = 1'b1;
            PH_ZERO: begin
              if (c == CH_X_LO || c == CH_X_UP) number_phase_next = PH_X;
              else if (is_dec && dval <= 4'd7) begin
                number_phase_next = PH_DIGITS;
                acc_en            = 1'b1;
              end else number_phase_next = PH_STOP;
            end
            PH_X: begin
              if (is_hex) begin
                number_phase_next = PH_DIGITS;
                radix_select_next = RX_HEX;
                acc_en            = 1'b1;
              end else number_phase_next = PH_STOP;
            end
            PH_DIGITS: begin
              if (is_hex && (5'(dval) < base)) acc_en = 1'b1;
              else number_phase_next = PH_STOP;
            end
            default: ;
          endcase
          if (lead_like) begin
            if (c == CH_ZERO) begin
              number_phase_next = PH_ZERO;
              radix_select_next = RX_OCT;
            end else if (is_dec) begin
              number_phase_next = PH_DIGITS;
              radix_select_next = RX_DEC;
              acc_en            = 1'b1;
            end else begin
              number_phase_next = PH_STOP;
            end
          end
          if (acc_en && !overflowed) begin
            if (prod[67:64] != 4'd0) overflowed_next = 1'b1;
            else                     magnitude_next  = prod[63:0];
          end
        end
      end

      if (close_rec || emit_comma) begin
        push               = 1'b1;
        number_phase_next  = PH_LEAD;
        negative_sign_next = 1'b0;
        radix_select_next  = RX_DEC;
        magnitude_next     = '0;
        overflowed_next    = 1'b0;
      end
      if (close_rec) begin
        field_counter_next    = '0;
        record_has_bytes_next = 1'b0;
      end
    end

    field_last = close_rec;
    if (close_rec && !record_has_bytes) begin
      res_new.field_value  = '0;
      res_new.field_index  = '0;
      res_new.field_stored = 1'b0;
      res_new.record_end   = 1'b1;
      res_new.empty_record = 1'b1;
    end else begin
      res_new.field_value  = negative_sign ? (64'd0 - sat) : sat;
      res_new.field_index  = 16'(field_counter);
      res_new.field_stored = cnt_lt;
      res_new.record_end   = field_last;
      res_new.empty_record = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_phase     <= PH_LEAD;
      negative_sign    <= 1'b0;
      radix_select     <= RX_DEC;
      magnitude        <= '0;
      overflowed       <= 1'b0;
      field_counter    <= '0;
      record_has_bytes <= 1'b0;
      pending          <= PT_NONE;
    end else begin
      number_phase     <= number_phase_next;
      negative_sign    <= negative_sign_next;
      radix_select     <= radix_select_next;
      magnitude        <= magnitude_next;
      overflowed       <= overflowed_next;
      field_counter    <= field_counter_next;
      record_has_bytes <= record_has_bytes_next;
      pending          <= pending_next;
    end
  end

  // ---------------------------------------------------------------- output buffer
  assign s_tready = (count != 2'd2);
  assign m_tvalid = (count != 2'd0);
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;

  assign m_tdata  = {ent0.field_index, ent0.field_value};
  assign m_tlast  = ent0.record_end;
  assign m_tuser  = {ent0.empty_record, ent0.field_stored};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, m_acc})
        2'b11: begin
          if (count == 2'd1) ent0 <= res_new;
          else begin
            ent0 <= ent1;
            ent1 <= res_new;
          end
        end
        2'b01: begin
          ent0  <= ent1;
          count <= count - 2'd1;
        end
        2'b10: begin
          if (count == 2'd0) ent0 <= res_new;
          else               ent1 <= res_new;
          count <= count + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- assertions
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push |=> m_tvalid)
    else $error("result pushed but no output valid");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tlast |=> !record_has_bytes && (field_counter == '0) && (pending == PT_NONE))
    else $error("end of text did not reset record state");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && (m_tdata == 80'd0))
    else $error("malformed empty record marker");

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push)
    else $error("output buffer overfilled");

  a_cnt_sat: assert property (@(posedge clk) disable iff (rst)
    field_counter == CNT_MAX |=> (field_counter == CNT_MAX) || (field_counter == '0))
    else $error("field counter wrapped");

endmodule
